// ----- hw/rtl/mlcd_pkg.sv -----
// Shared constants, command and status types and helpers for the memory LCD frame buffer.
`timescale 1ns / 1ps

package mlcd_pkg;

    // Panel geometry
    localparam int LINE_PIXELS = 400;
    localparam int LINE_COUNT  = 240;
    localparam int LINE_BYTES  = (LINE_PIXELS + 7) / 8;
    localparam int STORE_BYTES = LINE_BYTES * LINE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int BYTE_W      = $clog2(LINE_BYTES);
    localparam int CUR_W       = 8;
    localparam int COORD_W     = 9;

    // Display command bits
    localparam logic [7:0] CMD_WRITE = 8'h80;
    localparam logic [7:0] CMD_VCOM  = 8'h40;
    localparam logic [7:0] CMD_CLEAR = 8'h20;

    // Input actions
    localparam logic [2:0] ACT_WRITE_PIXEL = 3'd0;
    localparam logic [2:0] ACT_READ_PIXEL  = 3'd1;
    localparam logic [2:0] ACT_FILL_BLACK  = 3'd2;
    localparam logic [2:0] ACT_FILL_WHITE  = 3'd3;
    localparam logic [2:0] ACT_CLEAR       = 3'd4;
    localparam logic [2:0] ACT_REFRESH     = 3'd5;

    // Output byte sources
    localparam logic [2:0] OUT_PIXEL      = 3'd0;
    localparam logic [2:0] OUT_PIXEL_MISS = 3'd1;
    localparam logic [2:0] OUT_CLEAR_CMD  = 3'd2;
    localparam logic [2:0] OUT_WRITE_CMD  = 3'd3;
    localparam logic [2:0] OUT_LINE_ADDR  = 3'd4;
    localparam logic [2:0] OUT_DATA       = 3'd5;
    localparam logic [2:0] OUT_ZERO       = 3'd6;

    typedef struct packed {
        logic       capture;
        logic       addr_load_loc;
        logic       addr_load_line;
        logic       addr_load_zero;
        logic       addr_inc;
        logic       mem_rd;
        logic       mem_wr;
        logic       wr_fill;
        logic       out_load;
        logic [2:0] out_sel;
        logic       out_release;
        logic       out_last;
        logic       vcom_toggle;
        logic       cursor_clear;
        logic       cursor_inc;
        logic       byte_clear;
        logic       byte_inc;
    } mlcd_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       in_bounds;
        logic       cursor_zero;
        logic       cursor_final;
        logic       byte_last;
        logic       addr_last;
        logic       load_ok;
    } mlcd_status_t;

    // Reverse the bit order of a byte
    function automatic logic [7:0] flip8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/mlcd_datapath.sv -----
// Datapath: item registers, address generation, frame store, line state and output register.
`timescale 1ns / 1ps

module mlcd_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mlcd_pkg::mlcd_cmd_t            cmd,
    output mlcd_pkg::mlcd_status_t         status,
    input  logic [2:0]                     action,
    input  logic [mlcd_pkg::COORD_W-1:0]   x,
    input  logic [mlcd_pkg::COORD_W-1:0]   y,
    input  logic                           color,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [1:0]                     cfg_data,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic                           kind,
    output logic [7:0]                     serial_byte,
    output logic                           pixel_value,
    output logic                           release_select,
    output logic                           last
);
    import mlcd_pkg::*;

    logic [2:0]         action_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic               color_reg;
    logic [1:0]         rotation_reg;
    logic               vcom_reg;
    logic [CUR_W-1:0]   cursor_reg;
    logic [CUR_W-1:0]   cursor_eff;
    logic [CUR_W:0]     cursor_plus;
    logic [BYTE_W-1:0]  byte_cnt_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [2:0]         bit_reg;
    logic [7:0]         mem [0:STORE_BYTES-1];
    logic [7:0]         rd_data_reg;
    logic [7:0]         wr_data;
    logic [7:0]         bit_mask;

    logic [9:0]         xw;
    logic [9:0]         yw;
    logic [9:0]         w_lim;
    logic [9:0]         h_lim;
    logic [9:0]         px;
    logic [9:0]         py;
    logic [ADDR_W-1:0]  loc_idx;
    logic [ADDR_W-1:0]  line_base;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               kind_reg;
    logic               kind_next;
    logic [7:0]         byte_reg;
    logic [7:0]         byte_next;
    logic               pixel_reg;
    logic               pixel_next;
    logic               release_reg;
    logic               last_reg;

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            x_reg      <= x;
            y_reg      <= y;
            color_reg  <= color;
        end
    end

    // Rotation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= 2'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rotation_reg <= cfg_data;
        end
    end

    // Map logical coordinates through the rotation to a store index
    always_comb
    begin
        xw    = {1'b0, x_reg};
        yw    = {1'b0, y_reg};
        w_lim = rotation_reg[0] ? 10'(LINE_COUNT) : 10'(LINE_PIXELS);
        h_lim = rotation_reg[0] ? 10'(LINE_PIXELS) : 10'(LINE_COUNT);
        case (rotation_reg)
            2'd1:
            begin
                px = 10'(LINE_PIXELS - 1) - yw;
                py = xw;
            end
            2'd2:
            begin
                px = 10'(LINE_PIXELS - 1) - xw;
                py = 10'(LINE_COUNT - 1) - yw;
            end
            2'd3:
            begin
                px = yw;
                py = 10'(LINE_COUNT - 1) - xw;
            end
            default:
            begin
                px = xw;
                py = yw;
            end
        endcase
        loc_idx = ADDR_W'(py) * ADDR_W'(LINE_BYTES) + ADDR_W'(px >> 3);
    end

    // Line cursor as used by a refresh
    assign cursor_eff  = (cursor_reg >= CUR_W'(LINE_COUNT)) ? '0 : cursor_reg;
    assign cursor_plus = {1'b0, cursor_eff} + (CUR_W + 1)'(1);
    assign line_base   = ADDR_W'(cursor_eff) * ADDR_W'(LINE_BYTES);

    // Address counter
    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.addr_load_loc)
        begin
            addr_next = loc_idx;
        end
        else if (cmd.addr_load_line)
        begin
            addr_next = line_base;
        end
        else if (cmd.addr_load_zero)
        begin
            addr_next = '0;
        end
        else if (cmd.addr_inc)
        begin
            addr_next = addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (cmd.addr_load_loc)
        begin
            bit_reg <= px[2:0];
        end
    end

    // Line state: cursor, byte count and VCOM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcom_reg     <= 1'b1;
            cursor_reg   <= '0;
            byte_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.vcom_toggle)
            begin
                vcom_reg <= ~vcom_reg;
            end
            if (cmd.cursor_clear)
            begin
                cursor_reg <= '0;
            end
            else if (cmd.cursor_inc)
            begin
                cursor_reg <= cursor_plus[CUR_W-1:0];
            end
            if (cmd.byte_clear)
            begin
                byte_cnt_reg <= '0;
            end
            else if (cmd.byte_inc)
            begin
                byte_cnt_reg <= byte_cnt_reg + BYTE_W'(1);
            end
        end
    end

    // Store write data: pixel update or fill pattern
    assign bit_mask = 8'd1 << bit_reg;
    always_comb
    begin
        if (cmd.wr_fill)
        begin
            wr_data = {8{action_reg != ACT_FILL_BLACK}};
        end
        else if (color_reg)
        begin
            wr_data = rd_data_reg | bit_mask;
        end
        else
        begin
            wr_data = rd_data_reg & ~bit_mask;
        end
    end

    // Frame store, single port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[addr_reg] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Select the next result
    always_comb
    begin
        kind_next  = 1'b0;
        pixel_next = 1'b0;
        unique case (cmd.out_sel)
            OUT_PIXEL:
            begin
                kind_next  = 1'b1;
                pixel_next = rd_data_reg[bit_reg];
                byte_next  = 8'h00;
            end
            OUT_PIXEL_MISS:
            begin
                kind_next = 1'b1;
                byte_next = 8'h00;
            end
            OUT_CLEAR_CMD: byte_next = CMD_CLEAR | (vcom_reg ? CMD_VCOM : 8'h00);
            OUT_WRITE_CMD: byte_next = CMD_WRITE | (vcom_reg ? CMD_VCOM : 8'h00);
            OUT_LINE_ADDR: byte_next = flip8(cursor_plus[7:0]);
            OUT_DATA:      byte_next = flip8(rd_data_reg);
            default:       byte_next = 8'h00;
        endcase
    end

    // Output register
    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg    <= kind_next;
            byte_reg    <= byte_next;
            pixel_reg   <= pixel_next;
            release_reg <= cmd.out_release;
            last_reg    <= cmd.out_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign serial_byte    = byte_reg;
    assign pixel_value    = pixel_reg;
    assign release_select = release_reg;
    assign last           = last_reg;

    // Status to the controller
    assign status.action       = action_reg;
    assign status.in_bounds    = (xw < w_lim) && (yw < h_lim);
    assign status.cursor_zero  = (cursor_eff == '0);
    assign status.cursor_final = (cursor_plus >= (CUR_W + 1)'(LINE_COUNT));
    assign status.byte_last    = (byte_cnt_reg == BYTE_W'(LINE_BYTES - 1));
    assign status.addr_last    = (addr_reg == ADDR_W'(STORE_BYTES - 1));
    assign status.load_ok      = ~out_valid_reg | ~out_stall;

endmodule

// ----- hw/rtl/mlcd_ctrl.sv -----
// Controller state machine sequencing pixel access, fills, clear and line bursts.
`timescale 1ns / 1ps

module mlcd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  mlcd_pkg::mlcd_status_t status,
    output mlcd_pkg::mlcd_cmd_t    cmd
);
    import mlcd_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_WR_RD    = 4'd2;
    localparam logic [3:0] ST_WR_MOD   = 4'd3;
    localparam logic [3:0] ST_PIX_RD   = 4'd4;
    localparam logic [3:0] ST_PIX_ANS  = 4'd5;
    localparam logic [3:0] ST_PIX_MISS = 4'd6;
    localparam logic [3:0] ST_FILL     = 4'd7;
    localparam logic [3:0] ST_CLR_CMD  = 4'd8;
    localparam logic [3:0] ST_CLR_END  = 4'd9;
    localparam logic [3:0] ST_REF_CMD  = 4'd10;
    localparam logic [3:0] ST_REF_ADDR = 4'd11;
    localparam logic [3:0] ST_REF_RD   = 4'd12;
    localparam logic [3:0] ST_REF_DATA = 4'd13;
    localparam logic [3:0] ST_REF_TRL  = 4'd14;
    localparam logic [3:0] ST_REF_END  = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.action)
                    ACT_WRITE_PIXEL:
                    begin
                        if (status.in_bounds)
                        begin
                            cmd.addr_load_loc = 1'b1;
                            state_next        = ST_WR_RD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_READ_PIXEL:
                    begin
                        if (status.in_bounds)
                        begin
                            cmd.addr_load_loc = 1'b1;
                            state_next        = ST_PIX_RD;
                        end
                        else
                        begin
                            state_next = ST_PIX_MISS;
                        end
                    end
                    ACT_FILL_BLACK, ACT_FILL_WHITE:
                    begin
                        cmd.addr_load_zero = 1'b1;
                        state_next         = ST_FILL;
                    end
                    ACT_CLEAR:
                    begin
                        state_next = ST_CLR_CMD;
                    end
                    ACT_REFRESH:
                    begin
                        cmd.addr_load_line = 1'b1;
                        cmd.byte_clear     = 1'b1;
                        state_next = status.cursor_zero ? ST_REF_CMD : ST_REF_ADDR;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WR_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_WR_MOD;
            end
            ST_WR_MOD:
            begin
                cmd.mem_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PIX_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_PIX_ANS;
            end
            ST_PIX_ANS:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PIXEL;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PIX_MISS:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PIXEL_MISS;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_fill  = 1'b1;
                cmd.addr_inc = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR_CMD:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel     = OUT_CLEAR_CMD;
                    cmd.vcom_toggle = 1'b1;
                    state_next      = ST_CLR_END;
                end
            end
            ST_CLR_END:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load       = 1'b1;
                    cmd.out_release    = 1'b1;
                    cmd.out_last       = 1'b1;
                    cmd.cursor_clear   = 1'b1;
                    cmd.addr_load_zero = 1'b1;
                    state_next         = ST_FILL;
                end
            end
            ST_REF_CMD:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel     = OUT_WRITE_CMD;
                    cmd.vcom_toggle = 1'b1;
                    state_next      = ST_REF_ADDR;
                end
            end
            ST_REF_ADDR:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_LINE_ADDR;
                    state_next   = ST_REF_RD;
                end
            end
            ST_REF_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_REF_DATA;
            end
            ST_REF_DATA:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_DATA;
                    cmd.addr_inc = 1'b1;
                    cmd.byte_inc = 1'b1;
                    state_next   = status.byte_last ? ST_REF_TRL : ST_REF_RD;
                end
            end
            ST_REF_TRL:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load = 1'b1;
                    if (status.cursor_final)
                    begin
                        state_next = ST_REF_END;
                    end
                    else
                    begin
                        cmd.out_last   = 1'b1;
                        cmd.cursor_inc = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_REF_END:
            begin
                if (status.load_ok)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_release  = 1'b1;
                    cmd.out_last     = 1'b1;
                    cmd.cursor_clear = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/memory_lcd_framebuffer_refresh_top.sv -----
// Top level of the memory LCD frame buffer and serializer.
`timescale 1ns / 1ps

// One-bit frame buffer (50 bytes x 240 lines, single-port store with registered read) for a
// memory LCD. One item is handled at a time; the input is stalled from acceptance until the
// item has finished. A pixel write is a read-modify-write of one store byte; a pixel read
// answers after a store read, or without one when out of range. A fill writes one store
// byte per cycle; a clear command sends its command byte and a final byte, then fills the
// store. A refresh line sends the write command (first line only), the line address, the
// data bytes and a trailer byte (plus an extra trailer byte on the last line); each data
// byte needs a store read, then an output load. The store has no reset; it must be filled
// (fill or clear command) before any pixel access or refresh. Rotation may be written
// at any time the block is idle; cfg_ready is always high.
module memory_lcd_framebuffer_refresh_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   action,
    input  logic [mlcd_pkg::COORD_W-1:0] x,
    input  logic [mlcd_pkg::COORD_W-1:0] y,
    input  logic                         color,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [7:0]                   serial_byte,
    output logic                         pixel_value,
    output logic                         release_select,
    output logic                         last
);
    import mlcd_pkg::*;

    mlcd_cmd_t    cmd;
    mlcd_status_t status;

    assign cfg_ready = 1'b1;

    mlcd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mlcd_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (action),
        .x              (x),
        .y              (y),
        .color          (color),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .kind           (kind),
        .serial_byte    (serial_byte),
        .pixel_value    (pixel_value),
        .release_select (release_select),
        .last           (last)
    );

endmodule

// ----- hw/rtl/mlcd_checker.sv -----
// Port-level checks of the memory LCD frame buffer, bound to the top level.
`timescale 1ns / 1ps

module mlcd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       kind,
    input logic [7:0] serial_byte,
    input logic       pixel_value,
    input logic       release_select,
    input logic       last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(serial_byte) && $stable(kind)
            && $stable(pixel_value) && $stable(last))
        else $error("stalled result changed");

    // One item at a time: the input stalls right after a transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

    // A pixel answer is the only result of its item and carries no byte
    a_pixel_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> last && serial_byte == 8'h00 && !release_select)
        else $error("malformed pixel answer");

    // Chip select drops only on a final serial byte
    a_release_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && release_select |-> last && !kind && !pixel_value)
        else $error("release outside final byte");

endmodule

bind memory_lcd_framebuffer_refresh_top mlcd_checker u_mlcd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .serial_byte    (serial_byte),
    .pixel_value    (pixel_value),
    .release_select (release_select),
    .last           (last)
);
